FILE: rtl/nkls_pkg.sv
// shared types and constants for the nearest light selector
package nkls_pkg;

  localparam int CRD_W  = 24;
  localparam int DIST_W = 50;
  localparam int ID_W   = 16;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 4;

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_OFFER  = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef struct packed {
    logic                     occ;
    logic [DIST_W-1:0]        sq_dist;
    logic [ID_W-1:0]          id;
    logic signed [CRD_W-1:0]  x;
    logic signed [CRD_W-1:0]  y;
    logic signed [CRD_W-1:0]  z;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic offer;
    logic rotate;
    logic in_range;
    logic is_tail;
  } cell_ctl_t;

  typedef struct packed {
    logic  valid;
    req_e  op;
    slot_t light;
  } front_t;

endpackage

FILE: rtl/nearest_k_light_selector.sv
// top level: k nearest light selector with a chain of sorted slot cells
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    req_type, pos, off, light_id
//  out      source     out_valid_o / out_ready_i  slot_index .. last
//  cfg      sink       cfg_we_i                   cfg_wdata_i (active_count)
//
// begin and offer: one transfer per cycle while in_ready_o is high, through four register
// stages (translate, difference, square, sum); the slot chain registers the item from the
// sum stage. finish: the chain rotates once per result loaded into the output register;
// the finish passes the stages, then results leave back to back with no back pressure;
// input is held off from the finish reaching the chain until its last result is loaded.
// reset: every slot empty, active_count 3, vertex zero.
module nearest_k_light_selector #(
  parameter int MAX_SLOTS  = 8,
  parameter int COORD_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nkls_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_x_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_y_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_z_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_x_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_y_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_z_i,
  input  logic [nkls_pkg::ID_W-1:0]         light_id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nkls_pkg::IDX_W-1:0]        slot_index_o,
  output logic                              slot_valid_o,
  output logic [nkls_pkg::ID_W-1:0]         light_id_out_o,
  output logic [nkls_pkg::DIST_W-1:0]       distance_sq_o,
  output logic signed [nkls_pkg::CRD_W-1:0] light_x_o,
  output logic signed [nkls_pkg::CRD_W-1:0] light_y_o,
  output logic signed [nkls_pkg::CRD_W-1:0] light_z_o,
  output logic                              last_o
);
  import nkls_pkg::*;

  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int RST_CNT = (MAX_SLOTS < 3) ? MAX_SLOTS : 3;

  logic [NW-1:0] n_q, n_d;
  logic [IW-1:0] rpt_cnt_q;
  logic          out_valid_q;
  logic          busy, step, cnt_last, adv;
  logic [5:0]    cfg_ext;
  front_t        front;
  slot_t         slots [MAX_SLOTS];
  logic          found [MAX_SLOTS+1];
  cell_ctl_t     ctl [MAX_SLOTS];

  always_comb begin
    cfg_ext = 6'(cfg_wdata_i);
    if (cfg_ext == 6'd0) begin
      n_d = NW'(1);
    end else if (cfg_ext > 6'(MAX_SLOTS)) begin
      n_d = NW'(MAX_SLOTS);
    end else begin
      n_d = NW'(cfg_ext);
    end
  end

  assign busy     = front.valid && (front.op == REQ_FINISH);
  assign step     = busy && (!out_valid_q || out_ready_i);
  assign cnt_last = (NW'(rpt_cnt_q) == (n_q - NW'(1)));
  assign adv      = !busy || (step && cnt_last);
  assign in_ready_o = adv;

  nkls_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .req_i      (req_e'(req_type_i)),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .off_x_i    (off_x_i),
    .off_y_i    (off_y_i),
    .off_z_i    (off_z_i),
    .light_id_i (light_id_i),
    .front_o    (front)
  );

  assign found[0] = 1'b0;

  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
    assign ctl[k].clear    = front.valid && (front.op == REQ_BEGIN);
    assign ctl[k].offer    = front.valid && (front.op == REQ_OFFER);
    assign ctl[k].rotate   = step;
    assign ctl[k].in_range = NW'(k) < n_q;
    assign ctl[k].is_tail  = NW'(k) == (n_q - NW'(1));

    nkls_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[k]),
      .new_i   (front.light),
      .prev_i  ((k == 0) ? front.light : slots[(k == 0) ? 0 : k-1]),
      .next_i  ((k == MAX_SLOTS-1) ? slots[k] : slots[(k == MAX_SLOTS-1) ? k : k+1]),
      .wrap_i  (slots[0]),
      .found_i (found[k]),
      .found_o (found[k+1]),
      .slot_o  (slots[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= NW'(RST_CNT);
      rpt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= n_d;
      end
      if (step) begin
        rpt_cnt_q   <= cnt_last ? '0 : IW'(rpt_cnt_q + 1'b1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      slot_index_o   <= IDX_W'(rpt_cnt_q);
      slot_valid_o   <= slots[0].occ;
      light_id_out_o <= slots[0].occ ? slots[0].id : '0;
      distance_sq_o  <= slots[0].occ ? slots[0].sq_dist : '0;
      light_x_o      <= slots[0].occ ? slots[0].x : '0;
      light_y_o      <= slots[0].occ ? slots[0].y : '0;
      light_z_o      <= slots[0].occ ? slots[0].z : '0;
      last_o         <= cnt_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/nkls_cell.sv
// one slot of the sorted light list with its insert and rotate logic
module nkls_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nkls_pkg::cell_ctl_t ctl_i,
  input  nkls_pkg::slot_t    new_i,
  input  nkls_pkg::slot_t    prev_i,
  input  nkls_pkg::slot_t    next_i,
  input  nkls_pkg::slot_t    wrap_i,
  input  logic               found_i,
  output logic               found_o,
  output nkls_pkg::slot_t    slot_o
);
  import nkls_pkg::*;

  logic  occ_q, occ_d;
  slot_t data_q, data_d;
  logic  take;

  always_comb begin
    slot_o     = data_q;
    slot_o.occ = occ_q;
  end

  assign take    = ctl_i.in_range && (!occ_q || (new_i.sq_dist < data_q.sq_dist));
  assign found_o = found_i | take;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    priority if (ctl_i.clear) begin
      occ_d = 1'b0;
    end else if (ctl_i.offer && ctl_i.in_range) begin
      if (found_i) begin
        occ_d  = prev_i.occ;
        data_d = prev_i;
      end else if (take) begin
        occ_d  = 1'b1;
        data_d = new_i;
      end
    end else if (ctl_i.rotate && ctl_i.in_range) begin
      occ_d  = ctl_i.is_tail ? wrap_i.occ : next_i.occ;
      data_d = ctl_i.is_tail ? wrap_i : next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

FILE: rtl/nkls_front.sv
// translate, saturate and squared distance pipeline ahead of the slot chain
module nkls_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             in_valid_i,
  input  nkls_pkg::req_e                   req_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_x_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_y_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_z_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_x_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_y_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_z_i,
  input  logic [nkls_pkg::ID_W-1:0]        light_id_i,
  output nkls_pkg::front_t                 front_o
);
  import nkls_pkg::*;

  localparam int SW = CRD_W + 1;
  localparam int PW = 2 * SW;
  localparam int QW = DIST_W - 1;
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-(1 <<< (COORD_BITS - 1)));

  function automatic logic signed [COORD_BITS-1:0] sat_add(
    input logic signed [CRD_W-1:0] a,
    input logic signed [CRD_W-1:0] b
  );
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return COORD_BITS'(s);
  endfunction

  logic signed [CRD_W-1:0] vx_q, vy_q, vz_q;
  logic v1_q, v2_q, v3_q, v4_q;
  req_e op1_q, op2_q, op3_q, op4_q;
  logic [ID_W-1:0] id1_q, id2_q, id3_q, id4_q;
  logic signed [COORD_BITS-1:0] l1x_q, l1y_q, l1z_q;
  logic signed [COORD_BITS-1:0] l2x_q, l2y_q, l2z_q;
  logic signed [COORD_BITS-1:0] l3x_q, l3y_q, l3z_q;
  logic signed [COORD_BITS-1:0] l4x_q, l4y_q, l4z_q;
  logic signed [SW-1:0] d2x_q, d2y_q, d2z_q;
  logic signed [PW-1:0] px, py, pz;
  logic [QW-1:0] q3x_q, q3y_q, q3z_q;
  logic [DIST_W-1:0] dist4_q;

  assign px = d2x_q * d2x_q;
  assign py = d2y_q * d2y_q;
  assign pz = d2z_q * d2z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0;
      vy_q <= '0;
      vz_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      if (in_valid_i && (req_i == REQ_BEGIN)) begin
        vx_q <= pos_x_i;
        vy_q <= pos_y_i;
        vz_q <= pos_z_i;
      end
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q   <= req_i;
      id1_q   <= light_id_i;
      l1x_q   <= sat_add(pos_x_i, off_x_i);
      l1y_q   <= sat_add(pos_y_i, off_y_i);
      l1z_q   <= sat_add(pos_z_i, off_z_i);
      op2_q   <= op1_q;
      id2_q   <= id1_q;
      l2x_q   <= l1x_q;
      l2y_q   <= l1y_q;
      l2z_q   <= l1z_q;
      d2x_q   <= SW'(l1x_q) - SW'(vx_q);
      d2y_q   <= SW'(l1y_q) - SW'(vy_q);
      d2z_q   <= SW'(l1z_q) - SW'(vz_q);
      op3_q   <= op2_q;
      id3_q   <= id2_q;
      l3x_q   <= l2x_q;
      l3y_q   <= l2y_q;
      l3z_q   <= l2z_q;
      q3x_q   <= px[QW-1:0];
      q3y_q   <= py[QW-1:0];
      q3z_q   <= pz[QW-1:0];
      op4_q   <= op3_q;
      id4_q   <= id3_q;
      l4x_q   <= l3x_q;
      l4y_q   <= l3y_q;
      l4z_q   <= l3z_q;
      dist4_q <= DIST_W'(q3x_q) + DIST_W'(q3y_q) + DIST_W'(q3z_q);
    end
  end

  always_comb begin
    front_o.valid         = v4_q;
    front_o.op            = op4_q;
    front_o.light.occ     = 1'b1;
    front_o.light.sq_dist = dist4_q;
    front_o.light.id      = id4_q;
    front_o.light.x       = CRD_W'(l4x_q);
    front_o.light.y       = CRD_W'(l4y_q);
    front_o.light.z       = CRD_W'(l4z_q);
  end

endmodule

FILE: rtl/nkls_checker.sv
// port level checks for the nearest light selector
module nkls_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [nkls_pkg::IDX_W-1:0]        slot_index_o,
  input logic                              slot_valid_o,
  input logic [nkls_pkg::ID_W-1:0]         light_id_out_o,
  input logic [nkls_pkg::DIST_W-1:0]       distance_sq_o,
  input logic signed [nkls_pkg::CRD_W-1:0] light_x_o,
  input logic                              last_o
);
  import nkls_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_sq_o)
      && $stable(slot_index_o))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slot_valid_o |-> (light_id_out_o == '0) && (distance_sq_o == '0)
      && (light_x_o == '0))
    else $error("empty slot reported with nonzero payload");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside a report burst");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      slot_index_o == IDX_W'($past(slot_index_o) + 1'b1))
    else $error("slot index out of sequence");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o || slot_index_o == '0)
    else $error("report does not start at slot zero");

endmodule

bind nearest_k_light_selector nkls_checker u_nkls_checker (.*);

FILE: bench/light_rank_checker.sv
`timescale 1ns / 1ps
// checker for the nearest light selector: predicts slot reports and compares them
module light_rank_checker #(
  parameter int MAX_SLOTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nkls_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [1:0]                        req_type_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_x_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_y_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] pos_z_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_x_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_y_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] off_z_i,
  input  logic [nkls_pkg::ID_W-1:0]         light_id_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [nkls_pkg::IDX_W-1:0]        slot_index_i,
  input  logic                              slot_valid_i,
  input  logic [nkls_pkg::ID_W-1:0]         light_id_out_i,
  input  logic [nkls_pkg::DIST_W-1:0]       distance_sq_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] light_x_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] light_y_i,
  input  logic signed [nkls_pkg::CRD_W-1:0] light_z_i,
  input  logic                              last_i,
  output int                                mismatch_count_o,
  output int                                reports_due_o,
  output int                                reports_seen_o
);
  import nkls_pkg::*;

  localparam logic [CFG_W-1:0] COUNT_AT_RESET = 4'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [CRD_W-1:0]  z;
    logic              last;
  } slot_report_t;

  logic [CFG_W-1:0]        keep_count;
  logic signed [CRD_W-1:0] vtx_x, vtx_y, vtx_z;
  slot_t                   ranked [MAX_SLOTS];
  slot_report_t            reports_due [$];

  function automatic logic signed [CRD_W-1:0] moved_coord(logic signed [CRD_W-1:0] p,
                                                          logic signed [CRD_W-1:0] o);
    longint hi_v, lo_v, s;
    hi_v = (longint'(1) <<< (CRD_W - 1)) - 1;
    lo_v = -(longint'(1) <<< (CRD_W - 1));
    s = longint'(p) + longint'(o);
    if (s > hi_v) s = hi_v;
    if (s < lo_v) s = lo_v;
    return s[CRD_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sq_span(logic signed [CRD_W-1:0] a,
                                                logic signed [CRD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return DIST_W'(d * d);
  endfunction

  function automatic int kept_slots();
    if (keep_count == 0) return 1;
    if (int'(keep_count) > MAX_SLOTS) return MAX_SLOTS;
    return int'(keep_count);
  endfunction

  // first empty or strictly farther slot wins, later ones move down
  function automatic void rank_light(slot_t fresh);
    int n, j;
    n = kept_slots();
    j = n;
    for (int k = n - 1; k >= 0; k--) begin
      if (!ranked[k].occ || fresh.sq_dist < ranked[k].sq_dist) j = k;
    end
    if (j < n) begin
      for (int k = n - 1; k > j; k--) ranked[k] = ranked[k-1];
      ranked[j] = fresh;
    end
  endfunction

  function automatic void queue_slot_reports();
    int n;
    slot_report_t r;
    n = kept_slots();
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.idx = IDX_W'(k);
      r.last = (k == n - 1);
      if (ranked[k].occ) begin
        r.valid = 1'b1;
        r.id = ranked[k].id;
        r.sq_dist = ranked[k].sq_dist;
        r.x = ranked[k].x;
        r.y = ranked[k].y;
        r.z = ranked[k].z;
      end
      reports_due.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slot_t        fresh;
    slot_report_t got, want;
    if (!rst_ni) begin
      keep_count = COUNT_AT_RESET;
      vtx_x = '0;
      vtx_y = '0;
      vtx_z = '0;
      for (int k = 0; k < MAX_SLOTS; k++) ranked[k] = '0;
      reports_due.delete();
      mismatch_count_o = 0;
      reports_seen_o = 0;
    end else begin
      if (cfg_we_i) keep_count = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        case (req_e'(req_type_i))
          REQ_BEGIN: begin
            vtx_x = pos_x_i;
            vtx_y = pos_y_i;
            vtx_z = pos_z_i;
            for (int k = 0; k < MAX_SLOTS; k++) ranked[k] = '0;
          end
          REQ_OFFER: begin
            fresh.occ = 1'b1;
            fresh.id = light_id_i;
            fresh.x = moved_coord(pos_x_i, off_x_i);
            fresh.y = moved_coord(pos_y_i, off_y_i);
            fresh.z = moved_coord(pos_z_i, off_z_i);
            fresh.sq_dist = sq_span(fresh.x, vtx_x) + sq_span(fresh.y, vtx_y) +
                            sq_span(fresh.z, vtx_z);
            rank_light(fresh);
          end
          REQ_FINISH: queue_slot_reports();
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{slot_index_i, slot_valid_i, light_id_out_i, distance_sq_i,
                light_x_i, light_y_i, light_z_i, last_i};
        reports_seen_o++;
        if (reports_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: unexpected slot report, slot %0d valid %0b id %h", $realtime,
                     got.idx, got.valid, got.id);
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: slot report mismatch, slot/valid/id/dist/x/y/z/last", $realtime);
              $display("  got  %0d %b %h %h %h %h %h %b", got.idx, got.valid, got.id,
                       got.sq_dist, got.x, got.y, got.z, got.last);
              $display("  want %0d %b %h %h %h %h %h %b", want.idx, want.valid, want.id,
                       want.sq_dist, want.x, want.y, want.z, want.last);
            end
          end
        end
      end
    end
    reports_due_o = reports_due.size();
  end

endmodule

FILE: bench/nearest_k_light_selector_tb.sv
`timescale 1ns / 1ps
// testbench top for the nearest light selector: stimulus, count settings and verdict
module nearest_k_light_selector_tb;
  import nkls_pkg::*;

  localparam int MAX_SLOTS    = 8;
  localparam int CLK_PERIOD   = 10;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam logic signed [CRD_W-1:0] COORD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] COORD_MIN = {1'b1, {(CRD_W-1){1'b0}}};
  localparam logic signed [CRD_W-1:0] COORD_ZERO = '0;
  localparam logic [ID_W-1:0] ID_ZERO = '0;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              req_type = '0;
  logic signed [CRD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [CRD_W-1:0] off_x = '0, off_y = '0, off_z = '0;
  logic [ID_W-1:0]         light_id = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        slot_index;
  logic                    slot_valid;
  logic [ID_W-1:0]         light_id_out;
  logic [DIST_W-1:0]       distance_sq;
  logic signed [CRD_W-1:0] light_x, light_y, light_z;
  logic                    last;

  int mismatches, reports_due, reports_seen;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int n_requests = 0;
  int n_queries = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  nearest_k_light_selector #(
    .MAX_SLOTS  (MAX_SLOTS),
    .COORD_BITS (CRD_W)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .off_x_i        (off_x),
    .off_y_i        (off_y),
    .off_z_i        (off_z),
    .light_id_i     (light_id),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .slot_index_o   (slot_index),
    .slot_valid_o   (slot_valid),
    .light_id_out_o (light_id_out),
    .distance_sq_o  (distance_sq),
    .light_x_o      (light_x),
    .light_y_o      (light_y),
    .light_z_o      (light_z),
    .last_o         (last)
  );

  light_rank_checker #(
    .MAX_SLOTS (MAX_SLOTS)
  ) rank_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .req_type_i       (req_type),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .pos_z_i          (pos_z),
    .off_x_i          (off_x),
    .off_y_i          (off_y),
    .off_z_i          (off_z),
    .light_id_i       (light_id),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .slot_index_i     (slot_index),
    .slot_valid_i     (slot_valid),
    .light_id_out_i   (light_id_out),
    .distance_sq_i    (distance_sq),
    .light_x_i        (light_x),
    .light_y_i        (light_y),
    .light_z_i        (light_z),
    .last_i           (last),
    .mismatch_count_o (mismatches),
    .reports_due_o    (reports_due),
    .reports_seen_o   (reports_seen)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic signed [CRD_W-1:0] rand_coord(int mode);
    case (mode)
      0: return CRD_W'($urandom);
      1: return CRD_W'(int'($urandom_range(8)) - 4);
      2: return CRD_W'(int'($urandom_range(1 << 16)) - (1 << 15));
      default: begin
        case ($urandom_range(3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return COORD_ZERO;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic push_req(req_e op, logic signed [CRD_W-1:0] px, py, pz, ox, oy, oz,
                          logic [ID_W-1:0] id);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= op;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    off_x <= ox;
    off_y <= oy;
    off_z <= oz;
    light_id <= id;
    do @(posedge clk); while (!in_ready);
    if (op != REQ_NOP) n_requests++;
  endtask

  task automatic push_op(req_e op);
    push_req(op, rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0),
             rand_coord(0), ID_W'($urandom));
  endtask

  task automatic push_light(int x, int ox, logic [ID_W-1:0] id);
    push_req(REQ_OFFER, CRD_W'(x), COORD_ZERO, COORD_ZERO, CRD_W'(ox), COORD_ZERO,
             COORD_ZERO, id);
  endtask

  // wait until every report is out and the pipeline has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    settle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_query(int lights);
    int mode;
    mode = $urandom_range(3);
    push_req(REQ_BEGIN, rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(0),
             rand_coord(0), rand_coord(0), ID_W'($urandom));
    repeat (lights) begin
      push_req(REQ_OFFER, rand_coord(mode), rand_coord(mode), rand_coord(mode),
               rand_coord(mode), rand_coord(mode), rand_coord(mode), ID_W'($urandom));
    end
    push_op(REQ_FINISH);
    if ($urandom_range(4) == 0) push_op(REQ_FINISH);
    n_queries++;
  endtask

  task automatic run_random(int budget);
    int start;
    start = n_requests;
    while (n_requests - start < budget) begin
      if ($urandom_range(99) < 80) run_query($urandom_range(12));
      else push_op(req_e'($urandom_range(3)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // report before any query, then an unused code
    push_op(REQ_FINISH);
    push_op(REQ_NOP);
    // vertex at the corner, lights saturating both ways, a tie and a discarded tie
    push_req(REQ_BEGIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_ZERO, COORD_ZERO, COORD_ZERO,
             ID_ZERO);
    push_req(REQ_OFFER, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
             16'hffff);
    push_req(REQ_OFFER, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
             16'h0000);
    push_req(REQ_OFFER, COORD_MAX, COORD_MAX, COORD_MAX, COORD_ZERO, COORD_ZERO, COORD_ZERO,
             16'h1234);
    push_req(REQ_OFFER, COORD_MIN, COORD_MIN, COORD_MIN, COORD_ZERO, COORD_ZERO, COORD_ZERO,
             16'h4321);
    push_op(REQ_FINISH);
    push_op(REQ_FINISH);

    // count changed within a query, stale slots beyond the shorter count
    write_count(4'd8);
    push_req(REQ_BEGIN, COORD_ZERO, COORD_ZERO, COORD_ZERO, COORD_ZERO, COORD_ZERO,
             COORD_ZERO, ID_ZERO);
    push_light(5 * 256, 0, 16'd1);
    push_light(3 * 256, 0, 16'd2);
    push_light(7 * 256, 0, 16'd3);
    push_light(0, -3 * 256, 16'd4);
    push_light(256, 0, 16'd5);
    write_count(4'd2);
    push_light(2, 0, 16'd6);
    push_op(REQ_FINISH);
    write_count(4'd8);
    push_op(REQ_FINISH);
    write_count(4'd0);
    push_op(REQ_FINISH);
    write_count(4'd15);
    push_op(REQ_FINISH);
    push_req(REQ_BEGIN, COORD_MIN, COORD_ZERO, COORD_MAX, COORD_ZERO, COORD_ZERO, COORD_ZERO,
             ID_ZERO);
    push_op(REQ_FINISH);

    write_count(4'd5);
    send_idle_pct = 85;
    stall_pct = 0;
    run_random(18);

    write_count(4'd8);
    send_idle_pct = 0;
    stall_pct = 85;
    run_random(18);

    // long receiver hold-off while requests keep coming
    write_count(4'd8);
    stall_pct = 0;
    hold_requests++;
    run_query(6);
    repeat (3) push_op(REQ_FINISH);

    write_count(CFG_W'($urandom_range(15)));
    send_idle_pct = 22;
    stall_pct = 22;
    run_random(22);

    write_count(4'd1);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(14);

    settle();
    $display("covered %0d requests in %0d random queries, counts 0 to 15, idle and stall phases",
             n_requests, n_queries);
    $display("%0d slot reports compared, %0d mismatches", reports_seen, mismatches);
    if (mismatches == 0 && reports_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
